### hdl/blt_pkg.sv
// shared types and constants for the bounded list table
package blt_pkg;

	localparam int DEPTH  = 32;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;

	// request codes
	localparam logic [2:0] OP_APPEND     = 3'd0;
	localparam logic [2:0] OP_READ_AT    = 3'd1;
	localparam logic [2:0] OP_READ_FIRST = 3'd2;
	localparam logic [2:0] OP_READ_LAST  = 3'd3;
	localparam logic [2:0] OP_FIND       = 3'd4;
	localparam logic [2:0] OP_REMOVE     = 3'd5;

	// result status codes
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_FULL      = 2'd1;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
	localparam logic [1:0] STAT_RANGE     = 2'd3;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	// command broadcast to every cell
	typedef struct packed {
		logic              compare;
		logic              append;
		logic              remove;
		logic [DATA_W-1:0] value;
		logic [CNT_W-1:0]  count;
	} cell_cmd_t;

endpackage

### hdl/blt_cell.sv
// one list cell: holds an entry, compares it and shifts it on remove
module blt_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [blt_pkg::IDX_W-1:0]     cell_idx,
	input  blt_pkg::cell_cmd_t            cmd,
	input  logic [blt_pkg::DATA_W-1:0]    next_entry,
	input  logic                          seen_in,
	output logic [blt_pkg::DATA_W-1:0]    entry,
	output logic                          seen_out,
	output logic                          first_hit
);

	logic [blt_pkg::DATA_W-1:0] entry_q;
	logic                       match_q;
	logic                       in_use;
	logic                       at_tail;

	assign in_use  = {1'b0, cell_idx} < cmd.count;
	assign at_tail = ({1'b0, cell_idx} == cmd.count);

	// match flag is taken when the request is accepted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (cmd.compare) begin
			match_q <= in_use && (entry_q == cmd.value);
		end
	end

	// append loads the tail cell, remove pulls the neighbor down from the hit onward
	always_ff @(posedge clk) begin
		if (cmd.append && at_tail) begin
			entry_q <= cmd.value;
		end else if (cmd.remove && (seen_in || match_q)) begin
			entry_q <= next_entry;
		end
	end

	assign entry     = entry_q;
	assign seen_out  = seen_in || match_q;
	assign first_hit = match_q && !seen_in;

endmodule

### hdl/bounded_list_table.sv
// bounded list table: ordered list of signed words in a row of cells
// result: done is registered from the execute state that the accepting edge enters
// a new request is not accepted while busy; busy is high for the one execute cycle
// the compare on the accepting edge is followed by the hit chain and shift across the cells
// reset: arst_n clears the fill count and control state; entries are not cleared
// the receiver cannot stall: done is high for one cycle only; data, position and status hold until the next execute
module bounded_list_table (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [2:0]                        func,
	input  logic signed [blt_pkg::DATA_W-1:0] value,
	input  logic [blt_pkg::IDX_W-1:0]         index,
	output logic                              done,
	output logic signed [blt_pkg::DATA_W-1:0] data,
	output logic [blt_pkg::IDX_W-1:0]         position,
	output logic [1:0]                        status,
	output logic [blt_pkg::CNT_W-1:0]         count
);

	// control
	blt_pkg::state_t state_q, state_d;
	logic            accept;
	logic            exec;

	// latched request
	logic [2:0]                        func_q;
	logic [blt_pkg::DATA_W-1:0]        value_q;
	logic [blt_pkg::IDX_W-1:0]         index_q;

	// list state
	logic [blt_pkg::CNT_W-1:0]         count_q;

	// result registers
	logic                              done_q;
	logic [blt_pkg::DATA_W-1:0]        data_q;
	logic [blt_pkg::IDX_W-1:0]         pos_q;
	logic [1:0]                        status_q;

	// cell row wiring
	blt_pkg::cell_cmd_t                cmd;
	logic [blt_pkg::DATA_W-1:0]        entry_w [blt_pkg::DEPTH];
	logic                              seen_w  [blt_pkg::DEPTH+1];
	logic [blt_pkg::DEPTH-1:0]         first_w;

	// execute-cycle results
	logic [blt_pkg::IDX_W-1:0]         rd_addr;
	logic [blt_pkg::DATA_W-1:0]        rd_data;
	logic                              any_hit;
	logic                              full;
	logic                              empty;
	logic [blt_pkg::IDX_W-1:0]         hit_pos;
	logic [blt_pkg::DATA_W-1:0]        res_data;
	logic [blt_pkg::IDX_W-1:0]         res_pos;
	logic [1:0]                        res_status;
	logic [blt_pkg::CNT_W-1:0]         res_count;

	// ---------------------------------------------------------------
	// sequencer: idle -> execute -> idle
	// ---------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			blt_pkg::S_IDLE: begin
				if (start) state_d = blt_pkg::S_EXEC;
			end
			blt_pkg::S_EXEC: begin
				state_d = blt_pkg::S_IDLE;
			end
			default: begin
				state_d = blt_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		busy = 1'b0;
		exec = 1'b0;
		case (state_q)
			blt_pkg::S_IDLE: begin
				busy = 1'b0;
				exec = 1'b0;
			end
			blt_pkg::S_EXEC: begin
				busy = 1'b1;
				exec = 1'b1;
			end
			default: begin
				busy = 1'b0;
				exec = 1'b0;
			end
		endcase
	end

	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= blt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// request is held for the execute cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= func;
			value_q <= value;
			index_q <= index;
		end
	end

	// ---------------------------------------------------------------
	// command to the cells
	// compare happens on the accept edge with the incoming value;
	// append and remove act on the execute edge with the latched one
	// ---------------------------------------------------------------
	assign full  = (count_q == blt_pkg::CNT_W'(blt_pkg::DEPTH));
	assign empty = (count_q == '0);

	always_comb begin
		cmd.compare = accept;
		cmd.append  = exec && (func_q == blt_pkg::OP_APPEND) && !full;
		cmd.remove  = exec && (func_q == blt_pkg::OP_REMOVE);
		cmd.value   = exec ? value_q : value;
		cmd.count   = count_q;
	end

	// ---------------------------------------------------------------
	// row of cells; the hit flag ripples from cell zero upward so each
	// cell knows whether an earlier cell already matched
	// ---------------------------------------------------------------
	assign seen_w[0] = 1'b0;

	for (genvar k = 0; k < blt_pkg::DEPTH; k++) begin : g_cell
		logic [blt_pkg::DATA_W-1:0] nbr;
		if (k == blt_pkg::DEPTH - 1) begin : g_last
			assign nbr = entry_w[k];
		end else begin : g_mid
			assign nbr = entry_w[k+1];
		end

		blt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cell_idx   (blt_pkg::IDX_W'(k)),
			.cmd        (cmd),
			.next_entry (nbr),
			.seen_in    (seen_w[k]),
			.entry      (entry_w[k]),
			.seen_out   (seen_w[k+1]),
			.first_hit  (first_w[k])
		);
	end

	assign any_hit = seen_w[blt_pkg::DEPTH];

	// one-hot first hit to an index
	always_comb begin
		hit_pos = '0;
		for (int k = 0; k < blt_pkg::DEPTH; k++) begin
			if (first_w[k]) hit_pos = hit_pos | blt_pkg::IDX_W'(k);
		end
	end

	// single read port: first, last or indexed
	always_comb begin
		case (func_q)
			blt_pkg::OP_READ_FIRST: rd_addr = '0;
			blt_pkg::OP_READ_LAST:  rd_addr = blt_pkg::IDX_W'(count_q - blt_pkg::CNT_W'(1));
			default:                rd_addr = index_q;
		endcase
	end

	assign rd_data = entry_w[rd_addr];

	// ---------------------------------------------------------------
	// result of the execute cycle
	// ---------------------------------------------------------------
	always_comb begin
		res_data   = '0;
		res_pos    = '0;
		res_status = blt_pkg::STAT_OK;
		res_count  = count_q;
		case (func_q)
			blt_pkg::OP_APPEND: begin
				if (full) res_status = blt_pkg::STAT_FULL;
				else      res_count  = count_q + blt_pkg::CNT_W'(1);
			end
			blt_pkg::OP_READ_AT: begin
				if ({1'b0, index_q} < count_q) res_data   = rd_data;
				else                           res_status = blt_pkg::STAT_RANGE;
			end
			blt_pkg::OP_READ_FIRST, blt_pkg::OP_READ_LAST: begin
				if (!empty) res_data   = rd_data;
				else        res_status = blt_pkg::STAT_RANGE;
			end
			blt_pkg::OP_FIND: begin
				if (any_hit) res_pos    = hit_pos;
				else         res_status = blt_pkg::STAT_NOT_FOUND;
			end
			blt_pkg::OP_REMOVE: begin
				if (any_hit) res_count  = count_q - blt_pkg::CNT_W'(1);
				else         res_status = blt_pkg::STAT_NOT_FOUND;
			end
			default: begin
				res_status = blt_pkg::STAT_OK;
			end
		endcase
	end

	// fill count and strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= exec;
			if (exec) count_q <= res_count;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (exec) begin
			data_q   <= res_data;
			pos_q    <= res_pos;
			status_q <= res_status;
		end
	end

	assign done     = done_q;
	assign data     = data_q;
	assign position = pos_q;
	assign status   = status_q;
	assign count    = count_q;

endmodule
